// ----- src/rlpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlpc_pkg
// Types and constants shared by the radio link ping-pong controller.
// ----------------------------------------------------------------------------
package rlpc_pkg;

    // main states
    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_WAIT_TX = 3'd1;
    localparam logic [2:0] ST_TX_SEND = 3'd2;
    localparam logic [2:0] ST_TX_WAIT = 3'd3;
    localparam logic [2:0] ST_TX_HOP  = 3'd4;
    localparam logic [2:0] ST_RX_ARM  = 3'd5;
    localparam logic [2:0] ST_RX_WAIT = 3'd6;
    localparam logic [2:0] ST_RX_HOP  = 3'd7;

    // reset and setup substates
    localparam logic [2:0] SUB_PIN_LOW   = 3'd0;
    localparam logic [2:0] SUB_LOW_WAIT  = 3'd1;
    localparam logic [2:0] SUB_PIN_HIGH  = 3'd2;
    localparam logic [2:0] SUB_HIGH_WAIT = 3'd3;
    localparam logic [2:0] SUB_TABLE     = 3'd4;
    localparam logic [2:0] SUB_SETUP     = 3'd5;
    localparam logic [2:0] SUB_IDENT     = 3'd6;

    // radio modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TX   = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ROLE_IS_RECEIVER   = 3'd0;
    localparam logic [2:0] REG_PRE_SEND_TICKS     = 3'd1;
    localparam logic [2:0] REG_ACK_WAIT_TICKS     = 3'd2;
    localparam logic [2:0] REG_RECEIVE_WAIT_TICKS = 3'd3;
    localparam logic [2:0] REG_REINIT_TICKS       = 3'd4;
    localparam logic [2:0] REG_DEFAULT_DIR_TICKS  = 3'd5;
    localparam logic [2:0] REG_DATA_HOLD_TICKS    = 3'd6;

    localparam logic [15:0] PULSE_TICKS  = 16'd10;
    localparam logic [7:0]  HOP_STEP     = 8'd10;
    localparam logic [7:0]  HOP_LIMIT    = 8'd40;
    localparam logic [15:0] CHIP_ID      = 16'hF413;
    localparam logic [6:0]  CH_MASK      = 7'h7F;
    localparam logic [3:0]  STATE_OFFSET = 4'd6;
    localparam logic [3:0]  LINK_MAX     = 4'd13;

    // input item, first field in the highest bits
    typedef struct packed {
        logic [15:0] chip_ident;
        logic [5:0]  fifo_read_pointer;
        logic        crc_bad;
        logic        packet_done;
    } in_item_t;

    // result item, first field in the highest bits
    typedef struct packed {
        logic [3:0] pad;
        logic [3:0] link_state;
        logic       restore_defaults;
        logic       take_payload;
        logic       send_payload;
        logic       chip_setup;
        logic       clear_fifo;
        logic [6:0] channel;
        logic [1:0] radio_mode;
        logic       mode_write;
        logic       reset_pin;
    } out_item_t;

    typedef struct packed {
        logic        role_is_receiver;
        logic [15:0] pre_send_ticks;
        logic [15:0] ack_wait_ticks;
        logic [15:0] receive_wait_ticks;
        logic [15:0] reinit_ticks;
        logic [15:0] default_dir_ticks;
        logic [15:0] data_hold_ticks;
    } cfg_t;

endpackage
`default_nettype wire

// ----- src/radio_link_pingpong_controller_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radio_link_pingpong_controller_top
// Tick-driven controller for a half-duplex ping-pong radio link.
// ----------------------------------------------------------------------------
// One transaction on the s_ channel is one 1 ms tick carrying the radio status
// sample; every tick yields exactly one result transaction on the m_ channel
// with the pin level, command strobes, mode, channel and link state.
// The tick passes an input register, one pass of state-update logic and a
// result register; it leaves the input register once the result register
// is empty or being taken. One tick per cycle is sustained while m_tready
// is high, as the combinational state update closes the state-register loop.
// The cfg_ port writes the seven configuration registers by index, one per
// cycle with write enable high; write only while no tick is in flight.
// At reset (rst_n low) the configuration returns to its defaults and the link
// restarts at the reset-pin-low step; both pipeline registers empty.
// When m_tready is low the result is held and one more tick is still taken
// into the input register; s_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module radio_link_pingpong_controller_top
    import rlpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // packet_done, crc_bad, fifo_read_pointer[5:0], chip_ident[15:0]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // reset_pin, mode_write, radio_mode[1:0], channel[6:0], clear_fifo,
    // chip_setup, send_payload, take_payload, restore_defaults,
    // link_state[3:0], zero fill[3:0]
    output logic [23:0]      m_tdata,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;

    logic [2:0]  main_state_reg,     main_state_next;
    logic [2:0]  init_substate_reg,  init_substate_next;
    logic [15:0] step_timer_reg,     step_timer_next;
    logic [15:0] pre_send_timer_reg, pre_send_timer_next;
    logic [15:0] reinit_timer_reg,   reinit_timer_next;
    logic [15:0] default_timer_reg,  default_timer_next;
    logic [15:0] data_timer_reg,     data_timer_next;
    logic [6:0]  hop_channel_reg,    hop_channel_next;
    logic        pin_level_reg,      pin_level_next;
    logic [1:0]  last_mode_reg,      last_mode_next;
    logic [6:0]  last_channel_reg,   last_channel_next;
    out_item_t   out_data_next;

    function automatic logic [15:0] dec_timer(input logic [15:0] t);
        return (t == 16'd0) ? 16'd0 : t - 16'd1;
    endfunction

    function automatic logic [6:0] next_hop(input logic [6:0] ch);
        logic [7:0] n;
        n = {1'b0, ch} + HOP_STEP;
        return (n >= HOP_LIMIT) ? 7'd0 : n[6:0];
    endfunction

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.role_is_receiver   <= 1'b0;
            cfg_reg.pre_send_ticks     <= 16'd5;
            cfg_reg.ack_wait_ticks     <= 16'd20;
            cfg_reg.receive_wait_ticks <= 16'd50;
            cfg_reg.reinit_ticks       <= 16'd1000;
            cfg_reg.default_dir_ticks  <= 16'd500;
            cfg_reg.data_hold_ticks    <= 16'd1000;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ROLE_IS_RECEIVER:   cfg_reg.role_is_receiver   <= cfg_data[0];
                REG_PRE_SEND_TICKS:     cfg_reg.pre_send_ticks     <= cfg_data;
                REG_ACK_WAIT_TICKS:     cfg_reg.ack_wait_ticks     <= cfg_data;
                REG_RECEIVE_WAIT_TICKS: cfg_reg.receive_wait_ticks <= cfg_data;
                REG_REINIT_TICKS:       cfg_reg.reinit_ticks       <= cfg_data;
                REG_DEFAULT_DIR_TICKS:  cfg_reg.default_dir_ticks  <= cfg_data;
                REG_DATA_HOLD_TICKS:    cfg_reg.data_hold_ticks    <= cfg_data;
                default: ;
            endcase
        end
    end

    // tick state update
    always_comb
    begin
        main_state_next     = main_state_reg;
        init_substate_next  = init_substate_reg;
        step_timer_next     = step_timer_reg;
        pre_send_timer_next = pre_send_timer_reg;
        reinit_timer_next   = reinit_timer_reg;
        default_timer_next  = default_timer_reg;
        data_timer_next     = data_timer_reg;
        hop_channel_next    = hop_channel_reg;
        pin_level_next      = pin_level_reg;
        last_mode_next      = last_mode_reg;
        last_channel_next   = last_channel_reg;
        out_data_next       = '0;

        case (main_state_reg)
            ST_INIT:
            begin
                case (init_substate_reg)
                    SUB_PIN_LOW:
                    begin
                        pin_level_next     = 1'b0;
                        step_timer_next    = PULSE_TICKS;
                        init_substate_next = SUB_LOW_WAIT;
                        reinit_timer_next  = 16'd0;
                        default_timer_next = 16'd0;
                    end
                    SUB_LOW_WAIT:
                    begin
                        if (step_timer_next == 16'd1)
                            init_substate_next = SUB_PIN_HIGH;
                        step_timer_next = dec_timer(step_timer_next);
                    end
                    SUB_PIN_HIGH:
                    begin
                        pin_level_next     = 1'b1;
                        step_timer_next    = PULSE_TICKS;
                        init_substate_next = SUB_HIGH_WAIT;
                    end
                    SUB_HIGH_WAIT:
                    begin
                        if (step_timer_next == 16'd1)
                            init_substate_next = SUB_TABLE;
                        step_timer_next = dec_timer(step_timer_next);
                    end
                    SUB_TABLE:
                    begin
                        out_data_next.chip_setup = 1'b1;
                        init_substate_next       = SUB_SETUP;
                    end
                    SUB_SETUP:
                    begin
                        last_mode_next           = MODE_IDLE;
                        last_channel_next        = hop_channel_next & CH_MASK;
                        out_data_next.mode_write = 1'b1;
                        out_data_next.clear_fifo = 1'b1;
                        out_data_next.chip_setup = 1'b1;
                        init_substate_next       = SUB_IDENT;
                        reinit_timer_next        = cfg_reg.reinit_ticks;
                    end
                    SUB_IDENT:
                    begin
                        if (in_data_reg.chip_ident == CHIP_ID)
                        begin
                            if (cfg_reg.role_is_receiver)
                                main_state_next = ST_RX_ARM;
                            else
                            begin
                                main_state_next     = ST_WAIT_TX;
                                pre_send_timer_next = cfg_reg.pre_send_ticks;
                            end
                            hop_channel_next         = 7'd0;
                            default_timer_next       = 16'd0;
                            last_mode_next           = MODE_IDLE;
                            last_channel_next        = 7'd0;
                            out_data_next.mode_write = 1'b1;
                            out_data_next.clear_fifo = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_WAIT_TX:
            begin
                if (pre_send_timer_next == 16'd1)
                    main_state_next = ST_TX_SEND;
                pre_send_timer_next = dec_timer(pre_send_timer_next);
            end
            ST_TX_SEND:
            begin
                out_data_next.clear_fifo   = 1'b1;
                out_data_next.send_payload = 1'b1;
                out_data_next.mode_write   = 1'b1;
                last_mode_next             = MODE_TX;
                last_channel_next          = hop_channel_next & CH_MASK;
                main_state_next            = ST_TX_WAIT;
                step_timer_next            = cfg_reg.ack_wait_ticks;
            end
            ST_TX_WAIT:
            begin
                if (in_data_reg.packet_done)
                begin
                    if (in_data_reg.fifo_read_pointer == 6'd0)
                    begin
                        main_state_next    = ST_RX_ARM;
                        step_timer_next    = 16'd0;
                        default_timer_next = cfg_reg.role_is_receiver ? 16'd0
                                                                      : cfg_reg.default_dir_ticks;
                        reinit_timer_next  = cfg_reg.reinit_ticks;
                    end
                    else
                        main_state_next = ST_TX_HOP;
                    last_mode_next           = MODE_IDLE;
                    last_channel_next        = 7'd0;
                    out_data_next.mode_write = 1'b1;
                    out_data_next.clear_fifo = 1'b1;
                end
                if (step_timer_next == 16'd1)
                    main_state_next = ST_TX_HOP;
                step_timer_next = dec_timer(step_timer_next);
            end
            ST_TX_HOP:
            begin
                step_timer_next  = cfg_reg.ack_wait_ticks;
                hop_channel_next = next_hop(hop_channel_next);
                main_state_next  = ST_TX_SEND;
            end
            ST_RX_ARM:
            begin
                out_data_next.clear_fifo = 1'b1;
                out_data_next.mode_write = 1'b1;
                last_mode_next           = MODE_RX;
                last_channel_next        = hop_channel_next & CH_MASK;
                main_state_next          = ST_RX_WAIT;
                step_timer_next          = cfg_reg.receive_wait_ticks;
            end
            ST_RX_WAIT:
            begin
                if (in_data_reg.packet_done && !in_data_reg.crc_bad)
                begin
                    out_data_next.take_payload = 1'b1;
                    data_timer_next            = cfg_reg.data_hold_ticks;
                    default_timer_next         = cfg_reg.role_is_receiver
                                                 ? cfg_reg.default_dir_ticks : 16'd0;
                    main_state_next            = ST_WAIT_TX;
                    pre_send_timer_next        = cfg_reg.pre_send_ticks;
                    reinit_timer_next          = cfg_reg.reinit_ticks;
                    step_timer_next            = 16'd0;
                    last_mode_next             = MODE_IDLE;
                    last_channel_next          = hop_channel_next & CH_MASK;
                    out_data_next.mode_write   = 1'b1;
                    out_data_next.clear_fifo   = 1'b1;
                end
                if (step_timer_next == 16'd1)
                begin
                    main_state_next          = ST_RX_HOP;
                    last_mode_next           = MODE_IDLE;
                    last_channel_next        = hop_channel_next & CH_MASK;
                    out_data_next.mode_write = 1'b1;
                    out_data_next.clear_fifo = 1'b1;
                end
                step_timer_next = dec_timer(step_timer_next);
            end
            default:
            begin
                step_timer_next  = cfg_reg.receive_wait_ticks;
                hop_channel_next = next_hop(hop_channel_next);
                main_state_next  = ST_RX_ARM;
            end
        endcase

        // watchdogs
        if (reinit_timer_next == 16'd1)
        begin
            main_state_next    = ST_INIT;
            init_substate_next = SUB_PIN_LOW;
            default_timer_next = 16'd0;
        end
        reinit_timer_next = dec_timer(reinit_timer_next);

        if (default_timer_next == 16'd1)
        begin
            main_state_next    = ST_INIT;
            init_substate_next = SUB_IDENT;
        end
        default_timer_next = dec_timer(default_timer_next);

        if (data_timer_next == 16'd1)
        begin
            data_timer_next                = cfg_reg.data_hold_ticks;
            out_data_next.restore_defaults = 1'b1;
        end
        else
            data_timer_next = dec_timer(data_timer_next);

        out_data_next.reset_pin  = pin_level_next;
        out_data_next.radio_mode = last_mode_next;
        out_data_next.channel    = last_channel_next;
        out_data_next.link_state = (main_state_next == ST_INIT)
                                   ? {1'b0, init_substate_next}
                                   : {1'b0, main_state_next} + STATE_OFFSET;
        out_data_next.pad        = 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            main_state_reg     <= ST_INIT;
            init_substate_reg  <= SUB_PIN_LOW;
            step_timer_reg     <= 16'd0;
            pre_send_timer_reg <= 16'd0;
            reinit_timer_reg   <= 16'd0;
            default_timer_reg  <= 16'd0;
            data_timer_reg     <= 16'd1;
            hop_channel_reg    <= 7'd0;
            pin_level_reg      <= 1'b1;
            last_mode_reg      <= MODE_IDLE;
            last_channel_reg   <= 7'd0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                main_state_reg     <= main_state_next;
                init_substate_reg  <= init_substate_next;
                step_timer_reg     <= step_timer_next;
                pre_send_timer_reg <= pre_send_timer_next;
                reinit_timer_reg   <= reinit_timer_next;
                default_timer_reg  <= default_timer_next;
                data_timer_reg     <= data_timer_next;
                hop_channel_reg    <= hop_channel_next;
                pin_level_reg      <= pin_level_next;
                last_mode_reg      <= last_mode_next;
                last_channel_reg   <= last_channel_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= in_item_t'(s_tdata);
        if (advance)
            out_data_reg <= out_data_next;
    end

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    a_link_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_data_reg.link_state <= LINK_MAX))
        else $error("link state out of range");

    a_send_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_data_reg.send_payload) |->
        (out_data_reg.mode_write && out_data_reg.radio_mode == MODE_TX))
        else $error("payload sent without transmit mode write");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, out_data_reg.channel} < HOP_LIMIT))
        else $error("channel outside hop range");

    a_hop_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ({1'b0, hop_channel_reg} < HOP_LIMIT))
        else $error("hop channel outside hop range");

endmodule
`default_nettype wire
